[src/knck_pkg.sv]
// ----------------------------------------------------------------------------
// knck_pkg: shared types and codes for the k nearest candidate keeper
// Field widths, command and result codes, and the control/status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package knck_pkg;

    localparam int ID_W   = 32;
    localparam int DIST_W = 32;
    localparam int AGE_W  = 32;
    localparam int NC_W   = 5;
    localparam int FILL_W = 5;
    localparam int STAT_W = 2;

    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 72;
    localparam int M_USER_W = 3;

    localparam logic CMD_OFFER = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_REJECTED = 2'd1;
    localparam logic [STAT_W-1:0] ST_SKIPPED  = 2'd2;
    localparam logic [STAT_W-1:0] ST_DRAINED  = 2'd3;

    localparam logic [NC_W-1:0] NC_RESET = 5'd4;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
        logic [AGE_W-1:0]  age;
    } knck_entry_t;

    typedef struct packed {
        logic              load_in;
        logic              scan_clr;
        logic              scan_run;
        logic              rd_last;
        logic              evict_wr;
        logic              insert;
        logic              stat_load;
        logic [STAT_W-1:0] stat_code;
        logic              out_offer;
        logic              out_drain;
        logic              out_empty;
        logic              drain_end;
    } knck_cmd_t;

    typedef struct packed {
        logic is_drain;
        logic skip;
        logic held_lt_k;
        logic held_zero;
        logic held_full;
        logic take;
        logic scan_done;
        logic trim_needed;
        logic drain_last;
        logic out_free;
    } knck_stat_t;

endpackage

[src/k_nearest_candidate_keeper_core.sv]
// ----------------------------------------------------------------------------
// k_nearest_candidate_keeper_core: keeps the k nearest candidates of a query
// Input stream carries offers and drain requests; output stream carries
// one result per offer and the kept list, farthest first, per drain.
//
// Usage:
//   s_ channel: tuser = cmd (offer or drain), tdata = item_id, query_id,
//   distance. m_ channel: tuser = status, entry_valid; tdata = out_id,
//   out_distance, fill_count; tlast marks the final result of a request.
//   The APB register at offset 0 sets neighbor_count (clamped to 1..depth);
//   write it only while the block is idle.
//   Sequence: an offer below the count is inserted and its result loaded
//   into the output register; an offer on a list at or above the count
//   scans the list and, if nearer, evicts the farthest when the store is full
//   and inserts; it then checks the count, with a scan and an eviction per
//   trim eviction. A drain scans once per emitted entry, since every result
//   needs a full scan through the single read port of the store.
//   One request is worked at a time; a new one is taken while the last
//   result still waits in the output register.
//   Reset empties the list, clears the insertion stamp and sets the count
//   to 4. When m_tready is low the result is held and the sequencer waits
//   before loading the next one.
// ----------------------------------------------------------------------------
module k_nearest_candidate_keeper_core
    import knck_pkg::*;
#(
    parameter int LIST_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // item_id[31:0], query_id[63:32], distance[95:64]
    input  logic [0:0]          s_tuser,   // cmd[0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // out_id[31:0], out_distance[63:32], fill_count[68:64]
    output logic [M_USER_W-1:0] m_tuser,   // status[1:0], entry_valid[2]
    output logic                m_tlast,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [NC_W-1:0] nc_reg;
    logic            cfg_wr;
    knck_cmd_t       cmd;
    knck_stat_t      stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nc_reg <= NC_RESET;
        end else if (cfg_wr) begin
            nc_reg <= pwdata[NC_W-1:0];
        end
    end

    assign prdata = (paddr[2] == 1'b0) ? {{(32-NC_W){1'b0}}, nc_reg} : 32'd0;

    knck_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat_i   (stat),
        .cmd_o    (cmd)
    );

    knck_dp #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .neighbor_count (nc_reg),
        .cmd_i          (cmd),
        .stat_o         (stat),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast)
    );

endmodule

[src/knck_dp.sv]
// ----------------------------------------------------------------------------
// knck_dp: entry store, farthest-entry scan and result register
// Holds the kept entries in a single-port-read memory, scans them one per
// cycle for the farthest (oldest on ties), and formats the results.
// ----------------------------------------------------------------------------
module knck_dp
    import knck_pkg::*;
#(
    parameter int LIST_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [S_DATA_W-1:0] s_tdata,   // item_id, query_id, distance
    input  logic [0:0]          s_tuser,   // cmd
    input  logic [NC_W-1:0]     neighbor_count,
    input  knck_cmd_t           cmd_i,
    output knck_stat_t          stat_o,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // out_id, out_distance, fill_count, pad
    output logic [M_USER_W-1:0] m_tuser,   // status, entry_valid
    output logic                m_tlast
);

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int CMP_W = (CNT_W > NC_W) ? CNT_W : NC_W;

    // request latch
    logic              in_cmd_reg;
    logic [ID_W-1:0]   in_id_reg;
    logic [ID_W-1:0]   in_query_reg;
    logic [DIST_W-1:0] in_dist_reg;

    // list state
    knck_entry_t       mem [LIST_DEPTH];
    knck_entry_t       rd_data_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    knck_entry_t       wr_data;
    logic [CNT_W-1:0]  held_reg;
    logic [AGE_W-1:0]  ic_reg;
    logic [LIST_DEPTH-1:0] used_reg;
    logic [CNT_W-1:0]  drain_cnt_reg;
    logic [STAT_W-1:0] res_status_reg;

    // scan
    logic [CNT_W-1:0]  scan_addr_reg;
    logic              pv_reg;
    logic [IDX_W-1:0]  pidx_reg;
    logic              best_valid_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [ID_W-1:0]   best_id_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic [AGE_W-1:0]  best_ad_reg;
    logic              issue;
    logic [AGE_W-1:0]  cand_ad;
    logic              cand_first;
    logic              cand_use;

    // output register
    logic              m_valid_reg;
    logic [STAT_W-1:0] o_status_reg;
    logic              o_ev_reg;
    logic [ID_W-1:0]   o_id_reg;
    logic [DIST_W-1:0] o_dist_reg;
    logic [FILL_W-1:0] o_fill_reg;
    logic              o_last_reg;

    logic [CMP_W-1:0]  nc_ext;
    logic [CMP_W-1:0]  depth_c;
    logic [CMP_W-1:0]  k_eff;
    logic [CMP_W-1:0]  held_ext;
    logic [CNT_W-1:0]  held_m1;

    always_comb begin
        nc_ext   = CMP_W'(neighbor_count);
        depth_c  = CMP_W'(LIST_DEPTH);
        held_ext = CMP_W'(held_reg);
        if (nc_ext == '0) begin
            k_eff = CMP_W'(1);
        end else if (nc_ext > depth_c) begin
            k_eff = depth_c;
        end else begin
            k_eff = nc_ext;
        end
    end

    assign held_m1 = held_reg - CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (cmd_i.load_in) begin
            in_cmd_reg   <= s_tuser[0];
            in_id_reg    <= s_tdata[ID_W-1:0];
            in_query_reg <= s_tdata[2*ID_W-1:ID_W];
            in_dist_reg  <= s_tdata[2*ID_W+DIST_W-1:2*ID_W];
        end
    end

    // ---- entry store ----
    assign rd_addr = cmd_i.rd_last ? held_m1[IDX_W-1:0] : scan_addr_reg[IDX_W-1:0];

    always_comb begin
        wr_en   = cmd_i.insert | cmd_i.evict_wr;
        wr_addr = best_idx_reg;
        wr_data = rd_data_reg;
        if (cmd_i.insert) begin
            wr_addr = held_reg[IDX_W-1:0];
            wr_data = '{id: in_id_reg, distance: in_dist_reg, age: ic_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // ---- scan for the entry that leaves first ----
    assign issue    = cmd_i.scan_run && (scan_addr_reg != held_reg);
    assign cand_ad  = ic_reg - rd_data_reg.age;
    assign cand_use = pv_reg && !used_reg[pidx_reg];
    assign cand_first = !best_valid_reg
                     || (rd_data_reg.distance > best_dist_reg)
                     || ((rd_data_reg.distance == best_dist_reg) && (cand_ad > best_ad_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_addr_reg  <= '0;
            pv_reg         <= 1'b0;
            best_valid_reg <= 1'b0;
        end else if (cmd_i.scan_clr) begin
            scan_addr_reg  <= '0;
            pv_reg         <= 1'b0;
            best_valid_reg <= 1'b0;
        end else begin
            pv_reg <= issue;
            if (issue) begin
                scan_addr_reg <= scan_addr_reg + CNT_W'(1);
            end
            if (cand_use && cand_first) begin
                best_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pidx_reg <= scan_addr_reg[IDX_W-1:0];
        if (cand_use && cand_first) begin
            best_idx_reg  <= pidx_reg;
            best_id_reg   <= rd_data_reg.id;
            best_dist_reg <= rd_data_reg.distance;
            best_ad_reg   <= cand_ad;
        end
    end

    // ---- list bookkeeping ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg       <= '0;
            ic_reg         <= '0;
            used_reg       <= '0;
            drain_cnt_reg  <= '0;
            res_status_reg <= ST_INSERTED;
        end else begin
            if (cmd_i.stat_load) begin
                res_status_reg <= cmd_i.stat_code;
            end
            if (cmd_i.drain_end) begin
                held_reg      <= '0;
                used_reg      <= '0;
                drain_cnt_reg <= '0;
            end else begin
                if (cmd_i.insert) begin
                    held_reg <= held_reg + CNT_W'(1);
                    ic_reg   <= ic_reg + AGE_W'(1);
                end else if (cmd_i.evict_wr) begin
                    held_reg <= held_m1;
                end
                if (cmd_i.out_drain) begin
                    used_reg[best_idx_reg] <= 1'b1;
                    drain_cnt_reg          <= drain_cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    // ---- result register ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd_i.out_offer || cmd_i.out_drain || cmd_i.out_empty) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.out_offer) begin
            o_status_reg <= res_status_reg;
            o_ev_reg     <= 1'b0;
            o_id_reg     <= '0;
            o_dist_reg   <= '0;
            o_fill_reg   <= FILL_W'(held_reg);
            o_last_reg   <= 1'b1;
        end else if (cmd_i.out_empty) begin
            o_status_reg <= ST_DRAINED;
            o_ev_reg     <= 1'b0;
            o_id_reg     <= '0;
            o_dist_reg   <= '0;
            o_fill_reg   <= '0;
            o_last_reg   <= 1'b1;
        end else if (cmd_i.out_drain) begin
            o_status_reg <= ST_DRAINED;
            o_ev_reg     <= 1'b1;
            o_id_reg     <= best_id_reg;
            o_dist_reg   <= best_dist_reg;
            o_fill_reg   <= '0;
            o_last_reg   <= stat_o.drain_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, o_fill_reg, o_dist_reg, o_id_reg};
    assign m_tuser  = {o_ev_reg, o_status_reg};
    assign m_tlast  = o_last_reg;

    // ---- status to controller ----
    always_comb begin
        stat_o.is_drain    = (in_cmd_reg == CMD_DRAIN);
        stat_o.skip        = (in_id_reg == in_query_reg);
        stat_o.held_lt_k   = (held_ext < k_eff);
        stat_o.held_zero   = (held_reg == '0);
        stat_o.held_full   = (held_reg == CNT_W'(LIST_DEPTH));
        stat_o.take        = best_valid_reg && (in_dist_reg < best_dist_reg);
        stat_o.scan_done   = !pv_reg && (scan_addr_reg == held_reg);
        stat_o.trim_needed = (held_ext > k_eff);
        stat_o.drain_last  = ((drain_cnt_reg + CNT_W'(1)) == held_reg);
        stat_o.out_free    = !m_valid_reg || m_tready;
    end

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= CNT_W'(LIST_DEPTH))
        else $error("held count above list depth");

    a_insert_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.insert |-> (held_reg != CNT_W'(LIST_DEPTH)))
        else $error("insert into a full list");

    a_evict_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.evict_wr |-> (best_valid_reg && (held_reg != '0)))
        else $error("evict without a scanned entry");

    a_drain_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.out_drain |-> (best_valid_reg && !used_reg[best_idx_reg]))
        else $error("drain result without a fresh entry");
`endif

endmodule

[src/knck_ctrl.sv]
// ----------------------------------------------------------------------------
// knck_ctrl: request sequencer
// Steps each request through scan, evict, insert, trim and result phases
// by issuing commands to the datapath.
// ----------------------------------------------------------------------------
module knck_ctrl
    import knck_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  knck_stat_t stat_i,
    output knck_cmd_t  cmd_o
);

    typedef enum logic [11:0] {
        S_IDLE      = 12'b000000000001,
        S_DISPATCH  = 12'b000000000010,
        S_OSCAN     = 12'b000000000100,
        S_FEVICT    = 12'b000000001000,
        S_INSERT    = 12'b000000010000,
        S_TRIM      = 12'b000000100000,
        S_TSCAN     = 12'b000001000000,
        S_TEVICT    = 12'b000010000000,
        S_OFFER_OUT = 12'b000100000000,
        S_EMPTY     = 12'b001000000000,
        S_DSCAN     = 12'b010000000000,
        S_DOUT      = 12'b100000000000
    } knck_state_t;

    knck_state_t state_reg;
    knck_state_t state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd_o      = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_o.load_in = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (stat_i.is_drain) begin
                    if (stat_i.held_zero) begin
                        state_next = S_EMPTY;
                    end else begin
                        cmd_o.scan_clr = 1'b1;
                        state_next     = S_DSCAN;
                    end
                end else if (stat_i.skip) begin
                    cmd_o.stat_load = 1'b1;
                    cmd_o.stat_code = ST_SKIPPED;
                    state_next      = S_OFFER_OUT;
                end else if (stat_i.held_lt_k) begin
                    state_next = S_INSERT;
                end else begin
                    cmd_o.scan_clr = 1'b1;
                    state_next     = S_OSCAN;
                end
            end
            S_OSCAN: begin
                cmd_o.scan_run = 1'b1;
                if (stat_i.scan_done) begin
                    if (stat_i.take) begin
                        if (stat_i.held_full) begin
                            // no free slot: drop the farthest before appending
                            cmd_o.rd_last = 1'b1;
                            state_next    = S_FEVICT;
                        end else begin
                            state_next = S_INSERT;
                        end
                    end else begin
                        cmd_o.stat_load = 1'b1;
                        cmd_o.stat_code = ST_REJECTED;
                        state_next      = S_TRIM;
                    end
                end
            end
            S_FEVICT: begin
                cmd_o.evict_wr = 1'b1;
                state_next     = S_INSERT;
            end
            S_INSERT: begin
                cmd_o.insert    = 1'b1;
                cmd_o.stat_load = 1'b1;
                cmd_o.stat_code = ST_INSERTED;
                state_next      = S_TRIM;
            end
            S_TRIM: begin
                if (stat_i.trim_needed) begin
                    cmd_o.scan_clr = 1'b1;
                    state_next     = S_TSCAN;
                end else begin
                    state_next = S_OFFER_OUT;
                end
            end
            S_TSCAN: begin
                cmd_o.scan_run = 1'b1;
                if (stat_i.scan_done) begin
                    cmd_o.rd_last = 1'b1;
                    state_next    = S_TEVICT;
                end
            end
            S_TEVICT: begin
                cmd_o.evict_wr = 1'b1;
                state_next     = S_TRIM;
            end
            S_OFFER_OUT: begin
                if (stat_i.out_free) begin
                    cmd_o.out_offer = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_EMPTY: begin
                if (stat_i.out_free) begin
                    cmd_o.out_empty = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_DSCAN: begin
                cmd_o.scan_run = 1'b1;
                if (stat_i.scan_done) begin
                    state_next = S_DOUT;
                end
            end
            S_DOUT: begin
                if (stat_i.out_free) begin
                    cmd_o.out_drain = 1'b1;
                    if (stat_i.drain_last) begin
                        cmd_o.drain_end = 1'b1;
                        state_next      = S_IDLE;
                    end else begin
                        cmd_o.scan_clr = 1'b1;
                        state_next     = S_DSCAN;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[tb/sv/k_nearest_candidate_keeper_core_tb.sv]
// ----------------------------------------------------------------------------
// k_nearest_candidate_keeper_core_tb: self-checking bench for the keeper core
// Streams offer and drain requests into the core. A behavioral list model
// predicts every result, and the result stream is checked field by field.
// A directed table covers skips, ties, evictions and count clamping. Random
// query runs follow, with gaps and stalls on both streams, a long output
// hold-off, and neighbor_count rewritten between runs.
// ----------------------------------------------------------------------------
module k_nearest_candidate_keeper_core_tb;
    import knck_pkg::*;

    localparam int LIST_DEPTH    = 16;
    localparam int RANDOM_ITEMS  = 320;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 1500000;
    localparam logic [2:0] NEIGHBOR_COUNT_ADDR = 3'd0;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              entry_valid;
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
        logic [FILL_W-1:0] fill;
        logic              last;
    } neighbor_result_t;

    typedef struct packed {
        logic              is_cfg;
        logic [31:0]       cfg_word;
        logic              cmd;
        logic [ID_W-1:0]   item;
        logic [ID_W-1:0]   query;
        logic [DIST_W-1:0] distance;
        logic              typed;
        logic [STAT_W-1:0] want_status;
        logic [FILL_W-1:0] want_fill;
    } directed_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // item_id[31:0], query_id[63:32], distance[95:64]
    logic [0:0]          s_tuser;   // cmd[0]
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // out_id[31:0], out_distance[63:32], fill_count[68:64]
    logic [M_USER_W-1:0] m_tuser;   // status[1:0], entry_valid[2]
    logic                m_tlast;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // list model
    logic [ID_W-1:0]   list_id    [LIST_DEPTH];
    logic [DIST_W-1:0] list_dist  [LIST_DEPTH];
    logic [AGE_W-1:0]  list_stamp [LIST_DEPTH];
    logic [AGE_W-1:0]  stamp_next;
    int                list_fill;
    logic [NC_W-1:0]   k_setting;

    neighbor_result_t  pending_results[$];
    directed_row_t     directed_rows[$];
    logic [DIST_W-1:0] dist_pool [4];
    int                error_count;
    bit                stalls_on;
    bit                hold_out_req;

    k_nearest_candidate_keeper_core #(
        .LIST_DEPTH(LIST_DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int k_effective();
        if (k_setting == '0) return 1;
        if (k_setting > LIST_DEPTH) return LIST_DEPTH;
        return int'(k_setting);
    endfunction

    // farther wins; on a tie the older stamp (furthest behind stamp_next) wins
    function automatic bit leaves_first(int a, int b);
        logic [AGE_W-1:0] age_a;
        logic [AGE_W-1:0] age_b;
        if (list_dist[a] != list_dist[b]) return list_dist[a] > list_dist[b];
        age_a = stamp_next - list_stamp[a];
        age_b = stamp_next - list_stamp[b];
        return age_a > age_b;
    endfunction

    function automatic int farthest_slot(logic [LIST_DEPTH-1:0] taken);
        int best;
        best = -1;
        for (int i = 0; i < list_fill; i++) begin
            if (!taken[i] && (best < 0 || leaves_first(i, best))) best = i;
        end
        return best;
    endfunction

    // evicted slot is refilled from the top so the list stays packed
    function automatic void evict_farthest();
        int v;
        v = farthest_slot('0);
        if (v < 0) return;
        list_id[v]    = list_id[list_fill-1];
        list_dist[v]  = list_dist[list_fill-1];
        list_stamp[v] = list_stamp[list_fill-1];
        list_fill--;
    endfunction

    function automatic void predict_request(logic cmd, logic [ID_W-1:0] item,
                                            logic [ID_W-1:0] query,
                                            logic [DIST_W-1:0] cand_dist);
        neighbor_result_t      r;
        logic [LIST_DEPTH-1:0] taken;
        int                    k;
        int                    f;
        int                    n;
        bit                    take;
        r = '0;
        k = k_effective();
        if (cmd == CMD_OFFER) begin
            r.last = 1'b1;
            if (item == query) begin
                r.status = ST_SKIPPED;
            end else begin
                take = list_fill < k;
                if (!take && list_fill > 0) begin
                    f = farthest_slot('0);
                    take = cand_dist < list_dist[f];
                end
                if (take) begin
                    if (list_fill >= LIST_DEPTH) evict_farthest();
                    list_id[list_fill]    = item;
                    list_dist[list_fill]  = cand_dist;
                    list_stamp[list_fill] = stamp_next;
                    stamp_next = stamp_next + 1'b1;
                    list_fill++;
                    r.status = ST_INSERTED;
                end else begin
                    r.status = ST_REJECTED;
                end
                // also trims a list left over from a larger count
                while (list_fill > k) evict_farthest();
            end
            r.fill = FILL_W'(list_fill);
            pending_results.push_back(r);
        end else if (list_fill == 0) begin
            r.status = ST_DRAINED;
            r.last   = 1'b1;
            pending_results.push_back(r);
        end else begin
            taken = '0;
            n = list_fill;
            for (int j = 0; j < n; j++) begin
                f = farthest_slot(taken);
                taken[f]      = 1'b1;
                r.status      = ST_DRAINED;
                r.entry_valid = 1'b1;
                r.id          = list_id[f];
                r.distance    = list_dist[f];
                r.fill        = '0;
                r.last        = (j == n - 1);
                pending_results.push_back(r);
            end
            list_fill = 0;
        end
    endfunction

    function automatic int idle_len();
        int r;
        if (!stalls_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // pool draws make ties and equal-distance evictions common
    function automatic logic [DIST_W-1:0] pick_distance();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return dist_pool[$urandom_range(0, 3)];
        if (r < 40) return r[0] ? '1 : '0;
        return $urandom;
    endfunction

    function automatic void add_req(logic cmd, logic [ID_W-1:0] item, logic [ID_W-1:0] query,
                                    logic [DIST_W-1:0] cand_dist, logic typed,
                                    logic [STAT_W-1:0] status, logic [FILL_W-1:0] fill);
        directed_row_t row;
        row             = '0;
        row.cmd         = cmd;
        row.item        = item;
        row.query       = query;
        row.distance    = cand_dist;
        row.typed       = typed;
        row.want_status = status;
        row.want_fill   = fill;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg(logic [31:0] word);
        directed_row_t row;
        row          = '0;
        row.is_cfg   = 1'b1;
        row.cfg_word = word;
        directed_rows.push_back(row);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    task automatic set_neighbor_count(input logic [31:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= NEIGHBOR_COUNT_ADDR;
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        k_setting = word[NC_W-1:0];
    endtask

    task automatic send_request(input logic cmd, input logic [ID_W-1:0] item,
                                input logic [ID_W-1:0] query,
                                input logic [DIST_W-1:0] cand_dist);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {cand_dist, query, item};
        do @(posedge aclk); while (!s_tready);
        predict_request(cmd, item, query, cand_dist);
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : result_check
        neighbor_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got status %0d id %h last %b",
                         $time, m_tuser[1:0], m_tdata[31:0], m_tlast);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(m_tuser[1:0]));
                check_field("entry_valid", 32'(want.entry_valid), 32'(m_tuser[2]));
                check_field("out_id", want.id, m_tdata[31:0]);
                check_field("out_distance", want.distance, m_tdata[63:32]);
                check_field("fill_count", 32'(want.fill), 32'(m_tdata[68:64]));
                check_field("last", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    initial begin : result_sink
        int n;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_out_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_out_req = 1'b0;
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                n = idle_len();
                if (n > 0) begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("k_nearest_candidate_keeper_core test failed");
        $finish;
    end

    initial begin : stimulus
        neighbor_result_t typed_want;
        directed_row_t    row;
        logic [31:0]      word;
        logic [ID_W-1:0]  item;
        logic [ID_W-1:0]  query;
        int               phase;
        int               runs;
        int               r;
        int               random_sent;

        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        aresetn  <= 1'b0;
        error_count  = 0;
        stalls_on    = 1'b1;
        hold_out_req = 1'b0;
        list_fill    = 0;
        stamp_next   = '0;
        k_setting    = NC_RESET;

        // reset count of 4
        add_req(CMD_DRAIN, '1, '1, '1, 1'b1, ST_DRAINED, 5'd0);
        add_req(CMD_OFFER, 32'd1, 32'd1, 32'd5, 1'b1, ST_SKIPPED, 5'd0);
        add_req(CMD_OFFER, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_INSERTED, 5'd1);
        add_req(CMD_OFFER, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_INSERTED, 5'd2);
        add_req(CMD_OFFER, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0001_0000, 1'b1, ST_INSERTED, 5'd3);
        add_req(CMD_OFFER, 32'd7, 32'd9, 32'h0001_0000, 1'b1, ST_INSERTED, 5'd4);
        // equal to the farthest is not nearer
        add_req(CMD_OFFER, 32'd8, 32'd9, 32'hFFFF_FFFF, 1'b1, ST_REJECTED, 5'd4);
        add_req(CMD_OFFER, 32'd9, 32'd10, 32'h0001_0000, 1'b1, ST_INSERTED, 5'd4);
        add_req(CMD_OFFER, 32'd10, 32'd11, 32'h0001_0000, 1'b1, ST_REJECTED, 5'd4);
        add_req(CMD_OFFER, 32'd11, 32'd11, 32'd0, 1'b1, ST_SKIPPED, 5'd4);
        // evicts the oldest of three equally far entries
        add_req(CMD_OFFER, 32'd12, 32'd13, 32'h0000_FFFF, 1'b1, ST_INSERTED, 5'd4);
        add_req(CMD_DRAIN, '0, '0, '0, 1'b0, ST_DRAINED, '0);
        add_req(CMD_DRAIN, '0, '0, '0, 1'b1, ST_DRAINED, 5'd0);
        // count 0 behaves as 1; junk in the upper word bits
        add_cfg(32'hFFFF_FFE0);
        add_req(CMD_OFFER, 32'd20, 32'd21, 32'd100, 1'b1, ST_INSERTED, 5'd1);
        add_req(CMD_OFFER, 32'd22, 32'd21, 32'd50, 1'b1, ST_INSERTED, 5'd1);
        add_req(CMD_OFFER, 32'd23, 32'd21, 32'd50, 1'b1, ST_REJECTED, 5'd1);
        add_req(CMD_OFFER, 32'd24, 32'd21, 32'd0, 1'b1, ST_INSERTED, 5'd1);
        add_req(CMD_DRAIN, '0, '0, '0, 1'b0, ST_DRAINED, '0);
        // 31 clamps to the list depth
        add_cfg(32'h0000_001F);
        add_req(CMD_OFFER, 32'd30, 32'd31, 32'hFFFF_FFFF, 1'b1, ST_INSERTED, 5'd1);
        add_req(CMD_OFFER, 32'd31, 32'd30, 32'hFFFF_FFFF, 1'b1, ST_INSERTED, 5'd2);
        add_req(CMD_DRAIN, '0, '0, '0, 1'b0, ST_DRAINED, '0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                wait_idle();
                set_neighbor_count(row.cfg_word);
            end else begin
                send_request(row.cmd, row.item, row.query, row.distance);
                if (row.typed) begin
                    typed_want        = '0;
                    typed_want.status = row.want_status;
                    typed_want.fill   = row.want_fill;
                    typed_want.last   = 1'b1;
                    void'(pending_results.pop_back());
                    pending_results.push_back(typed_want);
                end
                pause_sender(idle_len());
            end
        end

        // random query runs; run 0 fills the list and run 1 lowers the count on it
        phase = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            wait_idle();
            word = $urandom;
            case (phase)
                0: word[NC_W-1:0] = 5'd16;
                1: word[NC_W-1:0] = 5'd3;
                2: word[NC_W-1:0] = 5'd31;
                3: word[NC_W-1:0] = 5'd0;
                4: word[NC_W-1:0] = 5'd1;
                5: word[NC_W-1:0] = 5'd17;
                default: ;
            endcase
            set_neighbor_count(word);
            stalls_on = ($urandom_range(0, 3) != 0);
            if (phase == 2 || $urandom_range(0, 9) == 0) hold_out_req = 1'b1;
            query = $urandom;
            foreach (dist_pool[i]) begin
                dist_pool[i] = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 15)) : $urandom;
            end
            runs = (phase == 0 || $urandom_range(0, 9) == 0) ? $urandom_range(24, 40)
                                                              : $urandom_range(1, 20);
            for (int i = 0; i < runs; i++) begin
                r = $urandom_range(0, 99);
                item = $urandom;
                if (r < 6) begin
                    send_request(CMD_OFFER, query, query, pick_distance());
                end else if (r < 9) begin
                    send_request(CMD_DRAIN, item, $urandom, $urandom);
                end else if (r < 14) begin
                    send_request(CMD_OFFER, item, $urandom, $urandom);
                end else begin
                    send_request(CMD_OFFER, item, query, pick_distance());
                end
                random_sent++;
                pause_sender(idle_len());
            end
            if (phase != 0 && $urandom_range(0, 3) != 0) begin
                send_request(CMD_DRAIN, $urandom, $urandom, $urandom);
                random_sent++;
                pause_sender(idle_len());
            end
            phase++;
        end

        wait_idle();
        if (error_count == 0) $display("k_nearest_candidate_keeper_core test passed");
        else $display("k_nearest_candidate_keeper_core test failed");
        $finish;
    end

endmodule
